### sv/sha_pkg.sv
// SHA-256 package: round constants, initial hash values, mixing functions, job types.
// No dependencies; imported by every module of the hasher.
package sha_pkg;

  localparam int QueueDepth = 4;

  // Item kinds handed from the front to the back.
  typedef enum logic [0:0] {
    JOB_BLOCK  = 1'b0,
    JOB_FINISH = 1'b1
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [511:0] block;
    logic [511:0] pad_block;
    logic        two_blocks;
  } job_t;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

### sv/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher, top level: front end, job queue, round engine.
// Steps: a block job runs load, 64 rounds and the hash add in the round
// engine; a finish job runs one or two such passes, then emits 8 digest words.
// Throughput: bursts of one byte per cycle while the queue absorbs blocks;
// the sustained rate is set by the single shared round unit.
// Reset loads initial hash values, empties queue.
module sha256_byte_stream_hasher import sha_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  logic fq_valid, fq_stall, qb_valid, qb_stall;
  job_t fq_job, qb_job;

  sha_front u_front (
    .clk, .rst, .in_valid, .in_stall, .mode, .data_byte,
    .job_valid(fq_valid), .job_stall(fq_stall), .job(fq_job)
  );

  sha_queue #(.Depth(Depth)) u_queue (
    .clk, .rst, .wr_valid(fq_valid), .wr_stall(fq_stall), .wr_job(fq_job),
    .rd_valid(qb_valid), .rd_stall(qb_stall), .rd_job(qb_job)
  );

  sha_back u_back (
    .clk, .rst, .job_valid(qb_valid), .job_stall(qb_stall), .job(qb_job),
    .valid(out_valid), .stall(out_stall), .digest_word, .word_index, .last_word
  );

`ifndef SYNTHESIS
  // Digest words come out in order.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_word |=> out_valid && word_index == $past(word_index) + 3'd1)
    else $error("digest word order broken");
  // Last flag only on the final word.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && last_word |-> word_index == 3'd7)
    else $error("last_word misplaced");
  // First word of a digest starts at index zero.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> word_index == 3'd0)
    else $error("digest does not start at word zero");
`endif

endmodule

### sv/sha_front.sv
// Front end: collects message bytes into blocks and builds padded blocks.
// Depends on sha_pkg; feeds jobs to sha_queue.
module sha_front import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  output logic        job_valid,
  input  logic        job_stall,
  output job_t        job
);

  // Block register, byte 0 in bits 511..504.
  logic [511:0] buffer;
  logic [5:0]  byte_count;
  logic [63:0] bit_length;
  logic        accept;
  logic [63:0] total;
  logic [511:0] cur;

  assign in_stall = job_stall;
  assign accept   = in_valid && !job_stall;
  assign total    = bit_length + {55'd0, byte_count, 3'd0};

  // Current buffer with the incoming byte placed at byte_count.
  always_comb begin
    for (int i = 0; i < 64; i++) begin
      cur[511 - 8*i -: 8] = (6'(i) == byte_count) ? data_byte : buffer[511 - 8*i -: 8];
    end
  end

  // Job assembly: full block on the 64th byte, padded block(s) on finish.
  always_comb begin
    job = '0;
    job_valid = 1'b0;
    job.two_blocks = byte_count > 6'd55;
    if (mode == 1'b0) begin
      job.kind = JOB_BLOCK;
      job.block = cur;
      job_valid = in_valid && (byte_count == 6'd63);
    end else begin
      job.kind = JOB_FINISH;
      job_valid = in_valid;
      for (int i = 0; i < 64; i++) begin
        if (6'(i) < byte_count) job.block[511 - 8*i -: 8] = buffer[511 - 8*i -: 8];
        else if (6'(i) == byte_count) job.block[511 - 8*i -: 8] = 8'h80;
        else job.block[511 - 8*i -: 8] = 8'h00;
      end
      if (byte_count <= 6'd55) job.block[63:0] = total;
      job.pad_block = {448'd0, total};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mode == 1'b0) begin
      buffer[511 - 8*byte_count -: 8] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      bit_length <= '0;
    end else if (accept) begin
      if (mode == 1'b1) begin
        byte_count <= '0;
        bit_length <= '0;
      end else begin
        byte_count <= byte_count + 6'd1;
        if (byte_count == 6'd63) bit_length <= bit_length + 64'd512;
      end
    end
  end

endmodule

### sv/sha_queue.sv
// Short job queue between the front end and the compression engine.
// Depends on sha_pkg.
module sha_queue import sha_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_stall,
  input  job_t wr_job,
  output logic rd_valid,
  input  logic rd_stall,
  output job_t rd_job
);

  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

  job_t          mem [Depth];
  logic [Aw-1:0] wr_ptr;
  logic [Aw-1:0] rd_ptr;
  logic [Aw:0]   count;
  logic          push;
  logic          pop;

  assign wr_stall = (count == (Aw+1)'(Depth));
  assign rd_valid = (count != '0);
  assign rd_job   = mem[rd_ptr];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == Aw'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == Aw'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

endmodule

### sv/sha_back.sv
// Back end: one SHA-256 round per cycle, hash update, digest emission.
// Depends on sha_pkg; takes jobs from sha_queue.
module sha_back import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_stall,
  input  job_t        job,
  output logic        valid,
  input  logic        stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROUND = 5'b00010,
    S_ADD   = 5'b00100,
    S_NEXT  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t      state, state_next;
  logic [31:0] hash [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [5:0]  round;
  logic        second;
  logic        finish;
  logic [511:0] pad;
  logic [31:0] wt, t1, t2;
  logic [31:0] w_new;

  assign job_stall = (state != S_IDLE);
  assign valid = (state == S_EMIT);
  assign digest_word = hash[word_index];
  assign last_word = (word_index == 3'd7);

  // Schedule: window w[0] holds W[t]; new word appended at w[15].
  assign w_new = ssig1(w[14]) + w[9] + ssig0(w[1]) + w[0];
  assign wt = w[0];
  assign t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[round] + wt;
  assign t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (job_valid) state_next = S_ROUND;
      S_ROUND: if (round == 6'd63) state_next = S_ADD;
      S_ADD:   state_next = !finish ? S_IDLE : (second ? S_NEXT : S_EMIT);
      S_NEXT:  state_next = S_ROUND;
      S_EMIT:  if (!stall && last_word) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      word_index <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= InitHash[i];
    end else begin
      state <= state_next;
      unique case (state)
        S_ADD: begin
          for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
        end
        S_EMIT: begin
          if (!stall) begin
            word_index <= word_index + 3'd1;
            if (last_word) begin
              for (int i = 0; i < 8; i++) hash[i] <= InitHash[i];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (job_valid) begin
          finish <= (job.kind == JOB_FINISH);
          second <= (job.kind == JOB_FINISH) && job.two_blocks;
          pad <= job.pad_block;
          for (int i = 0; i < 16; i++) w[i] <= job.block[511 - 32*i -: 32];
          for (int i = 0; i < 8; i++) v[i] <= hash[i];
          round <= '0;
        end
      end
      S_ROUND: begin
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= w_new;
        v[7] <= v[6];
        v[6] <= v[5];
        v[5] <= v[4];
        v[4] <= v[3] + t1;
        v[3] <= v[2];
        v[2] <= v[1];
        v[1] <= v[0];
        v[0] <= t1 + t2;
        round <= round + 6'd1;
      end
      S_NEXT: begin
        second <= 1'b0;
        for (int i = 0; i < 16; i++) w[i] <= pad[511 - 32*i -: 32];
        for (int i = 0; i < 8; i++) v[i] <= hash[i];
        round <= '0;
      end
      default: ;
    endcase
  end

endmodule

### tb/sv/sha256_byte_stream_hasher_tb.sv
// Testbench for sha256_byte_stream_hasher: directed and random byte messages are hashed by
// an in-bench SHA-256 predictor and the digest words are checked in order.
// Depends on sha_pkg (round constants, initial hash values) and the DUT.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_tb;
  import sha_pkg::*;

  localparam int ClkHalf = 6;
  localparam int CycleLimit = 400000;
  localparam logic ModeAppend = 1'b0;
  localparam logic ModeFinish = 1'b1;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_exp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  // Predictor state
  logic [31:0] hash_st [8];
  logic [7:0]  blk_bytes [64];
  int unsigned fill_cnt;
  logic [63:0] done_bits;
  digest_exp_t digest_q [$];

  int errors = 0;
  int idle_pct = 11;
  int unsigned cycles = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_cnt = 0;

  sha256_byte_stream_hasher dut (
    .clk, .rst, .in_valid, .in_stall, .mode, .data_byte,
    .out_valid, .out_stall, .digest_word, .word_index, .last_word
  );

  always #(ClkHalf) clk = ~clk;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One 64-round compression of blk_bytes into hash_st
  function automatic void compress_blk();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        wt = w[i];
      end else begin
        s0 = ror32(w[(i-15)&15], 7) ^ ror32(w[(i-15)&15], 18) ^ (w[(i-15)&15] >> 3);
        s1 = ror32(w[(i-2)&15], 17) ^ ror32(w[(i-2)&15], 19) ^ (w[(i-2)&15] >> 10);
        wt = s1 + w[(i-7)&15] + s0 + w[i&15];
        w[i&15] = wt;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + wt;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] += v[i];
  endfunction

  function automatic void restart_msg();
    for (int i = 0; i < 8; i++) hash_st[i] = InitHash[i];
    fill_cnt = 0;
    done_bits = '0;
  endfunction

  // Update the predictor with one accepted item
  function automatic void predict_item(input logic m, input logic [7:0] b);
    int unsigned pos;
    logic [63:0] total;
    digest_exp_t e;
    if (m == ModeAppend) begin
      blk_bytes[fill_cnt] = b;
      fill_cnt = (fill_cnt + 1) % 64;
      if (fill_cnt == 0) begin
        compress_blk();
        done_bits += 64'd512;
      end
      return;
    end
    pos = fill_cnt;
    blk_bytes[pos++] = 8'h80;
    if (pos > 56) begin
      while (pos < 64) blk_bytes[pos++] = 8'h00;
      compress_blk();
      pos = 0;
    end
    while (pos < 56) blk_bytes[pos++] = 8'h00;
    total = done_bits + 64'(fill_cnt) * 64'd8;
    for (int i = 0; i < 8; i++) blk_bytes[56+i] = total[63-8*i -: 8];
    compress_blk();
    for (int i = 0; i < 8; i++) begin
      e.word = hash_st[i];
      e.idx = 3'(i);
      e.last = (i == 7);
      digest_q.push_back(e);
    end
    restart_msg();
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    errors++;
  endtask

  // Offer one item, hold it until accepted
  task automatic send_item(input logic m, input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(m, b);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_item(ModeAppend, 8'($urandom));
    send_item(ModeFinish, 8'($urandom));
  endtask

  // Digest word checker and cycle limit
  always @(posedge clk) begin
    digest_exp_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", digest_word));
      end else begin
        e = digest_q.pop_front();
        if (digest_word !== e.word)
          report_mismatch($sformatf("word %0d: got %h exp %h", e.idx, digest_word, e.word));
        if (word_index !== e.idx)
          report_mismatch($sformatf("index: got %0d exp %0d", word_index, e.idx));
        if (last_word !== e.last)
          report_mismatch($sformatf("last on word %0d: got %b", e.idx, last_word));
      end
    end
  end

  // Receiver stall: random idling, one long hold on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 400;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // Empty message, "abc", byte extremes, ignored data on finish
  task automatic test_directed();
    send_item(ModeFinish, 8'h00);
    send_item(ModeAppend, 8'h61);
    send_item(ModeAppend, 8'h62);
    send_item(ModeAppend, 8'h63);
    send_item(ModeFinish, 8'hff);
    send_item(ModeAppend, 8'h00);
    send_item(ModeAppend, 8'hff);
    send_item(ModeAppend, 8'h55);
    send_item(ModeAppend, 8'haa);
    send_item(ModeFinish, 8'h5a);
    send_item(ModeFinish, 8'ha5);
  endtask

  // Random lengths, biased to the padding boundaries around 55/56/64 bytes
  task automatic test_random_messages();
    int sent;
    int len;
    sent = 0;
    while (sent < 190) begin
      case ($urandom_range(3))
        0: len = $urandom_range(12);
        1: len = $urandom_range(65, 53);
        2: len = $urandom_range(129, 118);
        default: len = $urandom_range(40);
      endcase
      send_message(len);
      sent += len + 1;
    end
  endtask

  // Back-to-back items and results with no idling
  task automatic test_full_rate();
    idle_pct = 0;
    send_message(64);
    send_message(0);
    send_message(56);
    send_message(3);
    idle_pct = 11;
  endtask

  // Receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) send_message($urandom_range(20, 1));
  endtask

  initial begin
    int waited;
    restart_msg();
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_rate();
    test_backpressure();
    test_random_messages();
    in_valid <= 1'b0;
    waited = 0;
    while (digest_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (digest_q.size() != 0)
      report_mismatch($sformatf("%0d digest words never arrived", digest_q.size()));
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
sv/sha_pkg.sv
sv/sha_front.sv
sv/sha_queue.sv
sv/sha_back.sv
sv/sha256_byte_stream_hasher.sv
tb/sv/sha256_byte_stream_hasher_tb.sv
